// File: src/lsdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsdc_pkg
// Types and constants for the lunar/solar date converter.
// ----------------------------------------------------------------------------
package lsdc_pkg;

    localparam logic CMD_S2L = 1'b0;
    localparam logic CMD_L2S = 1'b1;
    localparam int   ROM_SIZE = 151;
    localparam int   BASE_DN = 29;
    localparam int   STEM_BASE = 1864;
    localparam int   YEAR_W = 12;
    localparam int   OFF_W = 17;

    typedef struct packed {
        logic       cmd;
        logic [11:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic        in_leap_month;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic        out_leap_month;
        logic [3:0]  year_stem;
        logic [3:0]  year_branch;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GYEAR,
        ST_GMON,
        ST_LYEAR,
        ST_LMON,
        ST_SUMYEAR,
        ST_SUMMON,
        ST_GWALK,
        ST_GMWALK,
        ST_STEM,
        ST_DONE
    } t_state;

    // Gregorian month lengths, non-leap.
    function automatic logic [4:0] greg_mdays(input logic [3:0] m);
        case (m)
            4'd2:                      greg_mdays = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   greg_mdays = 5'd30;
            default:                   greg_mdays = 5'd31;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: src/lsdc_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsdc_rom
// Synchronous year-word memory with a registered read word.
// ----------------------------------------------------------------------------
module lsdc_rom (
    input  wire         i_clk,
    input  wire  [7:0]  i_addr,
    output logic [16:0] o_word
);
    logic [16:0] mem [0:lsdc_pkg::ROM_SIZE-1];
    logic [16:0] r_word;

    always_comb begin
        mem = '{
            17'h04BD8,17'h04AE0,17'h0A570,17'h054D5,17'h0D260,17'h0D950,17'h16554,
            17'h056A0,17'h09AD0,17'h055D2,17'h04AE0,17'h0A5B6,17'h0A4D0,17'h0D250,
            17'h1D255,17'h0B540,17'h0D6A0,17'h0ADA2,17'h095B0,17'h14977,17'h04970,
            17'h0A4B0,17'h0B4B5,17'h06A50,17'h06D40,17'h1AB54,17'h02B60,17'h09570,
            17'h052F2,17'h04970,17'h06566,17'h0D4A0,17'h0EA50,17'h06E95,17'h05AD0,
            17'h02B60,17'h186E3,17'h092E0,17'h1C8D7,17'h0C950,17'h0D4A0,17'h1D8A6,
            17'h0B550,17'h056A0,17'h1A5B4,17'h025D0,17'h092D0,17'h0D2B2,17'h0A950,
            17'h0B557,17'h06CA0,17'h0B550,17'h15355,17'h04DA0,17'h0A5B0,17'h14573,
            17'h052B0,17'h0A9A8,17'h0E950,17'h06AA0,17'h0AEA6,17'h0AB50,17'h04B60,
            17'h0AAE4,17'h0A570,17'h05260,17'h0F263,17'h0D950,17'h05B57,17'h056A0,
            17'h096D0,17'h04DD5,17'h04AD0,17'h0A4D0,17'h0D4D4,17'h0D250,17'h0D558,
            17'h0B540,17'h0B6A0,17'h195A6,17'h095B0,17'h049B0,17'h0A974,17'h0A4B0,
            17'h0B27A,17'h06A50,17'h06D40,17'h0AF46,17'h0AB60,17'h09570,17'h04AF5,
            17'h04970,17'h064B0,17'h074A3,17'h0EA50,17'h06B58,17'h055C0,17'h0AB60,
            17'h096D5,17'h092E0,17'h0C960,17'h0D954,17'h0D4A0,17'h0DA50,17'h07552,
            17'h056A0,17'h0ABB7,17'h025D0,17'h092D0,17'h0CAB5,17'h0A950,17'h0B4A0,
            17'h0BAA4,17'h0AD50,17'h055D9,17'h04BA0,17'h0A5B0,17'h15176,17'h052B0,
            17'h0A930,17'h07954,17'h06AA0,17'h0AD50,17'h05B52,17'h04B60,17'h0A6E6,
            17'h0A4E0,17'h0D260,17'h0EA65,17'h0D530,17'h05AA0,17'h076A3,17'h096D0,
            17'h04BD7,17'h04AD0,17'h0A4D0,17'h1D0B6,17'h0D250,17'h0D520,17'h0DD45,
            17'h0B5A0,17'h056D0,17'h055B2,17'h049B0,17'h0A577,17'h0A4B0,17'h0AA50,
            17'h1B255,17'h06D20,17'h0ADA0,17'h14B63};
    end

    always_ff @(posedge i_clk) begin
        if (i_addr < 8'(lsdc_pkg::ROM_SIZE)) begin
            r_word <= mem[i_addr];
        end else begin
            r_word <= '0;
        end
    end

    assign o_word = r_word;
endmodule
`default_nettype wire

// File: src/lunar_solar_date_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lunar_solar_date_convert
// Gregorian <-> Chinese lunar date converter driven by a year-word memory.
// ----------------------------------------------------------------------------
// One conversion at a time. A transaction is taken when the block is idle
// and its result sits in an output register until taken; the next request
// may be accepted once that result has been sent. The time a conversion
// takes is set by the sequencer walking the year-word memory (one word per
// cycle, through a registered read) and the Gregorian day counts, one year
// or month per cycle. cmd 0 gives lunar date and leap mark, cmd 1 the
// Gregorian date; status 1 flags an invalid or out-of-range request, with
// all other fields zero. Stem and branch index the lunar year.
// ----------------------------------------------------------------------------
module lunar_solar_date_convert #(
    parameter int FIRST_YEAR = 1900,
    parameter int NUM_YEARS  = 151
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  lsdc_pkg::t_in       i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output lsdc_pkg::t_out      o_data
);
    localparam int LAST = FIRST_YEAR + NUM_YEARS - 1;

    lsdc_pkg::t_state r_state, n_state;
    lsdc_pkg::t_in    r_req;
    lsdc_pkg::t_out   r_out;
    logic             r_ovalid;
    logic [7:0]       r_idx;     // year-word index
    logic             r_rd;      // word from memory valid this cycle
    logic [16:0]      r_w;       // word of the target year
    logic [17:0]      r_off;     // day offset
    logic [11:0]      r_gy;      // Gregorian year counter
    logic [3:0]       r_m;       // month counter
    logic             r_lphase;  // walking the leap month
    logic [11:0]      r_ly;      // lunar year for stem/branch

    logic [7:0]  rom_addr;
    logic [16:0] rom_word;

    lsdc_rom u_rom (.i_clk(i_clk), .i_addr(rom_addr), .o_word(rom_word));

    // y/100 by reciprocal multiply; leap when y%4==0 and (y%100!=0 or (y/100)%4==0)
    function automatic logic gleap(input logic [11:0] y);
        logic [24:0] p;
        logic [11:0] q100;
        logic [11:0] r100;
        p = 25'(y) * 25'd5243;
        q100 = 12'(p >> 19);
        r100 = y - 12'(q100 * 12'd100);
        gleap = (y[1:0] == 2'b00) && ((r100 != 12'd0) || (q100[1:0] == 2'b00));
    endfunction
    function automatic logic [8:0] ydays(input logic [16:0] w);
        ydays = 9'(9'd348 + 9'($countones(w[15:4])) +
                ((w[3:0] != 0) ? (w[16] ? 9'd30 : 9'd29) : 9'd0));
    endfunction
    function automatic logic [4:0] mdays(input logic [16:0] w, input logic [3:0] m);
        mdays = w[5'd16 - 5'(m)] ? 5'd30 : 5'd29;
    endfunction
    function automatic logic [4:0] gmlen(input logic [11:0] y, input logic [3:0] m);
        gmlen = 5'(lsdc_pkg::greg_mdays(m) + ((m == 4'd2 && gleap(y)) ? 5'd1 : 5'd0));
    endfunction

    logic        in_bad;
    logic [4:0]  cur_len;
    logic [8:0]  gyl;
    logic [4:0]  leap_len;
    // stem/branch: cycle position mod 10 and mod 12 (both divide 60)
    logic [7:0]  ly_rel;
    logic [15:0] p10, p12;
    logic [7:0]  q10, q12;
    logic [7:0]  r10, r12;

    assign o_stall = (r_state != lsdc_pkg::ST_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign rom_addr = r_idx;

    always_comb begin
        in_bad = (i_data.in_year < 12'(FIRST_YEAR)) || (i_data.in_year > 12'(LAST)) ||
                 (i_data.in_month == 0) || (i_data.in_month > 4'd12) || (i_data.in_day == 0);
        cur_len = mdays(r_w, r_m);
        leap_len = (r_w[3:0] == 0) ? 5'd0 : (r_w[16] ? 5'd30 : 5'd29);
        gyl = gleap(r_gy) ? 9'd366 : 9'd365;
        ly_rel = 8'(r_ly - 12'(lsdc_pkg::STEM_BASE));
        p10 = 16'(ly_rel) * 16'd205;
        p12 = 16'(ly_rel) * 16'd171;
        q10 = 8'(p10 >> 11);
        q12 = 8'(p12 >> 11);
        r10 = ly_rel - 8'(q10 * 8'd10);
        r12 = ly_rel - 8'(q12 * 8'd12);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsdc_pkg::ST_IDLE: if (i_valid && !o_stall) begin
                if (in_bad) n_state = lsdc_pkg::ST_DONE;
                else if (i_data.cmd == lsdc_pkg::CMD_S2L) begin
                    if (i_data.in_day > gmlen(i_data.in_year, i_data.in_month))
                        n_state = lsdc_pkg::ST_DONE;
                    else
                        n_state = lsdc_pkg::ST_GYEAR;
                end else n_state = lsdc_pkg::ST_LYEAR;
            end
            lsdc_pkg::ST_GYEAR: begin
                if (!(r_gy < r_req.in_year)) n_state = lsdc_pkg::ST_GMON;
            end
            lsdc_pkg::ST_GMON: begin
                if (!(r_m < r_req.in_month)) begin
                    if (r_off + 18'(r_req.in_day) <= 18'(lsdc_pkg::BASE_DN + 1))
                        n_state = lsdc_pkg::ST_DONE;
                    else
                        n_state = lsdc_pkg::ST_SUMYEAR;
                end
            end
            lsdc_pkg::ST_SUMYEAR: begin
                if (r_rd) begin
                    if (r_idx - 8'd1 >= 8'(NUM_YEARS)) n_state = lsdc_pkg::ST_DONE;
                    else if (r_off <= 18'(ydays(rom_word))) n_state = lsdc_pkg::ST_SUMMON;
                end
            end
            lsdc_pkg::ST_SUMMON: begin
                if (!r_lphase) begin
                    if (r_off <= 18'(cur_len)) n_state = lsdc_pkg::ST_STEM;
                    else if (r_w[3:0] != r_m && r_m == 4'd12) n_state = lsdc_pkg::ST_DONE;
                end else begin
                    if (r_off <= 18'(leap_len)) n_state = lsdc_pkg::ST_STEM;
                    else if (r_m == 4'd12) n_state = lsdc_pkg::ST_DONE;
                end
            end
            lsdc_pkg::ST_LYEAR: begin
                if (r_rd && !(12'(FIRST_YEAR) + 12'(r_idx - 8'd1) < r_req.in_year)) begin
                    if (r_req.in_leap_month && r_req.in_month != rom_word[3:0])
                        n_state = lsdc_pkg::ST_DONE;
                    else
                        n_state = lsdc_pkg::ST_LMON;
                end
            end
            lsdc_pkg::ST_LMON: begin
                if (!(r_m < r_req.in_month)) begin
                    if (r_req.in_leap_month)
                        n_state = (r_req.in_day > leap_len) ? lsdc_pkg::ST_DONE
                                                            : lsdc_pkg::ST_GWALK;
                    else
                        n_state = (r_req.in_day > cur_len) ? lsdc_pkg::ST_DONE
                                                           : lsdc_pkg::ST_GWALK;
                end
            end
            lsdc_pkg::ST_GWALK: begin
                if (r_off < 18'(gyl)) n_state = lsdc_pkg::ST_GMWALK;
                else if (r_gy + 12'd1 > 12'(LAST)) n_state = lsdc_pkg::ST_DONE;
            end
            lsdc_pkg::ST_GMWALK: begin
                if (!(r_m < 4'd12 && r_off >= 18'(gmlen(r_gy, r_m))))
                    n_state = lsdc_pkg::ST_STEM;
            end
            lsdc_pkg::ST_STEM: n_state = lsdc_pkg::ST_DONE;
            lsdc_pkg::ST_DONE: n_state = lsdc_pkg::ST_IDLE;
            default: n_state = lsdc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsdc_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_rd     <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_state <= n_state;
            case (r_state)
                lsdc_pkg::ST_IDLE: if (i_valid && !o_stall) begin
                    r_req <= i_data;
                    r_out <= lsdc_pkg::t_out'({1'b1, 30'd0});
                    r_gy <= 12'(FIRST_YEAR);
                    r_off <= '0;
                    r_m <= 4'd1;
                    r_idx <= '0;
                    r_rd <= 1'b0;
                    r_lphase <= 1'b0;
                end
                // Gregorian day number: whole years
                lsdc_pkg::ST_GYEAR: begin
                    if (r_gy < r_req.in_year) begin
                        r_off <= r_off + 18'(gyl);
                        r_gy <= r_gy + 12'd1;
                    end
                end
                lsdc_pkg::ST_GMON: begin
                    if (r_m < r_req.in_month) begin
                        r_off <= r_off + 18'(gmlen(r_gy, r_m));
                        r_m <= r_m + 4'd1;
                    end else begin
                        // day number = off + d - 1; need > 29
                        r_off <= r_off + 18'(r_req.in_day) - 18'(lsdc_pkg::BASE_DN + 1);
                        r_idx <= '0;
                        r_rd <= 1'b0;
                    end
                end
                // solar->lunar: walk year words
                lsdc_pkg::ST_SUMYEAR: begin
                    r_rd <= 1'b1;
                    if (r_rd && (r_idx - 8'd1 < 8'(NUM_YEARS))) begin
                        if (r_off <= 18'(ydays(rom_word))) begin
                            r_w <= rom_word;
                            r_ly <= 12'(FIRST_YEAR) + 12'(r_idx - 8'd1);
                            r_m <= 4'd1;
                            r_lphase <= 1'b0;
                        end else begin
                            r_off <= r_off - 18'(ydays(rom_word));
                        end
                    end
                    r_idx <= r_idx + 8'd1;
                end
                lsdc_pkg::ST_SUMMON: begin
                    if (!r_lphase) begin
                        if (r_off <= 18'(cur_len)) begin
                            r_out.out_leap_month <= 1'b0;
                        end else begin
                            r_off <= r_off - 18'(cur_len);
                            if (r_w[3:0] == r_m) r_lphase <= 1'b1;
                            else if (r_m != 4'd12) r_m <= r_m + 4'd1;
                        end
                    end else begin
                        if (r_off <= 18'(leap_len)) begin
                            r_out.out_leap_month <= 1'b1;
                        end else begin
                            r_off <= r_off - 18'(leap_len);
                            r_lphase <= 1'b0;
                            if (r_m != 4'd12) r_m <= r_m + 4'd1;
                        end
                    end
                end
                // lunar->solar: sum years before target
                lsdc_pkg::ST_LYEAR: begin
                    r_rd <= 1'b1;
                    r_idx <= r_idx + 8'd1;
                    if (r_rd) begin
                        if (12'(FIRST_YEAR) + 12'(r_idx - 8'd1) < r_req.in_year) begin
                            r_off <= r_off + 18'(ydays(rom_word));
                        end else begin
                            r_w <= rom_word;
                            r_ly <= r_req.in_year;
                            r_m <= 4'd1;
                        end
                    end
                end
                lsdc_pkg::ST_LMON: begin
                    if (r_m < r_req.in_month) begin
                        r_off <= r_off + 18'(cur_len);
                        r_m <= r_m + 4'd1;
                    end else if (r_req.in_leap_month) begin
                        r_off <= r_off + 18'(cur_len) + 18'(r_req.in_day) +
                                 18'(lsdc_pkg::BASE_DN);
                        r_gy <= 12'(FIRST_YEAR);
                    end else begin
                        r_off <= r_off + ((r_w[3:0] != 0 && r_m > r_w[3:0]) ?
                                 18'(leap_len) : 18'd0) + 18'(r_req.in_day) +
                                 18'(lsdc_pkg::BASE_DN);
                        r_gy <= 12'(FIRST_YEAR);
                    end
                end
                lsdc_pkg::ST_GWALK: begin
                    if (r_off < 18'(gyl)) begin
                        r_m <= 4'd1;
                    end else begin
                        r_off <= r_off - 18'(gyl);
                        r_gy <= r_gy + 12'd1;
                    end
                end
                lsdc_pkg::ST_GMWALK: begin
                    if (r_m < 4'd12 && r_off >= 18'(gmlen(r_gy, r_m))) begin
                        r_off <= r_off - 18'(gmlen(r_gy, r_m));
                        r_m <= r_m + 4'd1;
                    end else begin
                        r_off <= r_off + 18'd1;
                    end
                end
                lsdc_pkg::ST_STEM: begin
                    r_out.status <= 1'b0;
                    r_out.out_year <= (r_req.cmd == lsdc_pkg::CMD_S2L) ? r_ly : r_gy;
                    r_out.out_month <= r_m;
                    r_out.out_day <= r_off[4:0];
                    r_out.year_stem <= 4'(r10) + 4'd1;
                    r_out.year_branch <= 4'(r12) + 4'd1;
                end
                lsdc_pkg::ST_DONE: begin
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: dv/tb_lunar_solar_date_convert.sv
// ----------------------------------------------------------------------------
// tb_lunar_solar_date_convert
// Self-checking bench for the lunar/solar date converter: directed edge dates
// then random conversions in both directions, checked against a calendar
// predictor under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------

// Calendar predictor and store of expected conversions.
class date_scoreboard;
    localparam int FIRST = 1900;
    localparam int NYEARS = 151;
    localparam int LAST = FIRST + NYEARS - 1;

    bit [16:0] year_words[NYEARS];
    lsdc_pkg::t_out pending_dates[$];
    int n_checked;
    int n_errors;
    int n_invalid;

    function new();
        year_words = '{
            17'h04BD8,17'h04AE0,17'h0A570,17'h054D5,17'h0D260,17'h0D950,17'h16554,17'h056A0,
            17'h09AD0,17'h055D2,17'h04AE0,17'h0A5B6,17'h0A4D0,17'h0D250,17'h1D255,17'h0B540,
            17'h0D6A0,17'h0ADA2,17'h095B0,17'h14977,17'h04970,17'h0A4B0,17'h0B4B5,17'h06A50,
            17'h06D40,17'h1AB54,17'h02B60,17'h09570,17'h052F2,17'h04970,17'h06566,17'h0D4A0,
            17'h0EA50,17'h06E95,17'h05AD0,17'h02B60,17'h186E3,17'h092E0,17'h1C8D7,17'h0C950,
            17'h0D4A0,17'h1D8A6,17'h0B550,17'h056A0,17'h1A5B4,17'h025D0,17'h092D0,17'h0D2B2,
            17'h0A950,17'h0B557,17'h06CA0,17'h0B550,17'h15355,17'h04DA0,17'h0A5B0,17'h14573,
            17'h052B0,17'h0A9A8,17'h0E950,17'h06AA0,17'h0AEA6,17'h0AB50,17'h04B60,17'h0AAE4,
            17'h0A570,17'h05260,17'h0F263,17'h0D950,17'h05B57,17'h056A0,17'h096D0,17'h04DD5,
            17'h04AD0,17'h0A4D0,17'h0D4D4,17'h0D250,17'h0D558,17'h0B540,17'h0B6A0,17'h195A6,
            17'h095B0,17'h049B0,17'h0A974,17'h0A4B0,17'h0B27A,17'h06A50,17'h06D40,17'h0AF46,
            17'h0AB60,17'h09570,17'h04AF5,17'h04970,17'h064B0,17'h074A3,17'h0EA50,17'h06B58,
            17'h055C0,17'h0AB60,17'h096D5,17'h092E0,17'h0C960,17'h0D954,17'h0D4A0,17'h0DA50,
            17'h07552,17'h056A0,17'h0ABB7,17'h025D0,17'h092D0,17'h0CAB5,17'h0A950,17'h0B4A0,
            17'h0BAA4,17'h0AD50,17'h055D9,17'h04BA0,17'h0A5B0,17'h15176,17'h052B0,17'h0A930,
            17'h07954,17'h06AA0,17'h0AD50,17'h05B52,17'h04B60,17'h0A6E6,17'h0A4E0,17'h0D260,
            17'h0EA65,17'h0D530,17'h05AA0,17'h076A3,17'h096D0,17'h04BD7,17'h04AD0,17'h0A4D0,
            17'h1D0B6,17'h0D250,17'h0D520,17'h0DD45,17'h0B5A0,17'h056D0,17'h055B2,17'h049B0,
            17'h0A577,17'h0A4B0,17'h0AA50,17'h1B255,17'h06D20,17'h0ADA0,17'h14B63};
    endfunction

    function int leap_no(int yi);
        return int'(year_words[yi][3:0]);
    endfunction

    function int leap_len(int yi);
        if (year_words[yi][3:0] == 0) return 0;
        return year_words[yi][16] ? 30 : 29;
    endfunction

    function int lmon_len(int yi, int m);
        return year_words[yi][16 - m] ? 30 : 29;
    endfunction

    function int lyear_len(int yi);
        int s;
        s = leap_len(yi);
        for (int m = 1; m <= 12; m++) s += lmon_len(yi, m);
        return s;
    endfunction

    function bit is_greg_leap(int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function int gmon_len(int y, int m);
        case (m)
            2: return is_greg_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function lsdc_pkg::t_out convert(lsdc_pkg::t_in q);
        lsdc_pkg::t_out r;
        int y, m, d, off, yi, mo, lp, ly, gy, gm, c;
        bit found;
        r = '0;
        r.status = 1'b1;
        y = int'(q.in_year); m = int'(q.in_month); d = int'(q.in_day);
        if (y < FIRST || y > LAST || m < 1 || m > 12 || d < 1) return r;
        if (q.cmd == lsdc_pkg::CMD_S2L) begin
            if (d > gmon_len(y, m)) return r;
            off = d - 1;
            for (int i = 1900; i < y; i++) off += is_greg_leap(i) ? 366 : 365;
            for (int i = 1; i < m; i++) off += gmon_len(y, i);
            if (off <= lsdc_pkg::BASE_DN) return r;
            off -= lsdc_pkg::BASE_DN;
            for (yi = 0; yi < NYEARS; yi++) begin
                if (off <= lyear_len(yi)) break;
                off -= lyear_len(yi);
            end
            if (yi >= NYEARS) return r;
            lp = leap_no(yi);
            found = 0;
            for (mo = 1; mo <= 12; mo++) begin
                if (off <= lmon_len(yi, mo)) begin
                    found = 1; break;
                end
                off -= lmon_len(yi, mo);
                if (lp == mo) begin
                    if (off <= leap_len(yi)) begin
                        found = 1; r.out_leap_month = 1'b1; break;
                    end
                    off -= leap_len(yi);
                end
            end
            if (!found) begin
                r = '0; r.status = 1'b1; return r;
            end
            ly = FIRST + yi;
            r.out_year = 12'(ly); r.out_month = 4'(mo); r.out_day = 5'(off);
        end else begin
            yi = y - FIRST;
            lp = leap_no(yi);
            if (q.in_leap_month && m != lp) return r;
            off = 0;
            for (int i = 0; i < yi; i++) off += lyear_len(i);
            for (int i = 1; i < m; i++) off += lmon_len(yi, i);
            if (q.in_leap_month) begin
                off += lmon_len(yi, m);
                if (d > leap_len(yi)) return r;
            end else begin
                if (lp != 0 && m > lp) off += leap_len(yi);
                if (d > lmon_len(yi, m)) return r;
            end
            off += d + lsdc_pkg::BASE_DN;
            gy = 1900; gm = 1;
            while (off >= (is_greg_leap(gy) ? 366 : 365)) begin
                off -= is_greg_leap(gy) ? 366 : 365;
                gy++;
                if (gy > LAST) return r;
            end
            while (gm < 12 && off >= gmon_len(gy, gm)) begin
                off -= gmon_len(gy, gm);
                gm++;
            end
            ly = y;
            r.out_year = 12'(gy); r.out_month = 4'(gm); r.out_day = 5'(off + 1);
        end
        r.status = 1'b0;
        c = (ly - lsdc_pkg::STEM_BASE) % 60;
        r.year_stem = 4'(c % 10 + 1);
        r.year_branch = 4'(c % 12 + 1);
        return r;
    endfunction

    function void note_request(lsdc_pkg::t_in q);
        lsdc_pkg::t_out r;
        r = convert(q);
        if (r.status) n_invalid++;
        pending_dates.push_back(r);
    endfunction

    function void check_result(lsdc_pkg::t_out got);
        lsdc_pkg::t_out exp_r;
        if (pending_dates.size() == 0) begin
            $error("unexpected result transaction %h", got);
            n_errors++;
            return;
        end
        exp_r = pending_dates.pop_front();
        n_checked++;
        if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); n_errors++;
        end
        if (got.out_year !== exp_r.out_year) begin
            $error("out_year exp %0d got %0d", exp_r.out_year, got.out_year); n_errors++;
        end
        if (got.out_month !== exp_r.out_month) begin
            $error("out_month exp %0d got %0d", exp_r.out_month, got.out_month); n_errors++;
        end
        if (got.out_day !== exp_r.out_day) begin
            $error("out_day exp %0d got %0d", exp_r.out_day, got.out_day); n_errors++;
        end
        if (got.out_leap_month !== exp_r.out_leap_month) begin
            $error("out_leap_month exp %0d got %0d", exp_r.out_leap_month,
                   got.out_leap_month);
            n_errors++;
        end
        if (got.year_stem !== exp_r.year_stem) begin
            $error("year_stem exp %0d got %0d", exp_r.year_stem, got.year_stem); n_errors++;
        end
        if (got.year_branch !== exp_r.year_branch) begin
            $error("year_branch exp %0d got %0d", exp_r.year_branch, got.year_branch);
            n_errors++;
        end
    endfunction
endclass

module tb_lunar_solar_date_convert;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    lsdc_pkg::t_in  i_data = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    lsdc_pkg::t_out o_data;

    // Idle odds in percent for each side; changed per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_sent = 0;

    date_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    lunar_solar_date_convert i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Receiver: stall decided at the falling edge, results taken at the rising.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // Drive one request transaction; holds payload until accepted.
    task automatic send_request(lsdc_pkg::t_in q);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = q;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(q);
        n_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_date(bit c, int y, int m, int d, bit lf);
        lsdc_pkg::t_in q;
        q.cmd = c; q.in_year = 12'(y); q.in_month = 4'(m); q.in_day = 5'(d);
        q.in_leap_month = lf;
        send_request(q);
    endtask

    // Mostly in-range dates; a leap-flagged lunar date in a year that has a
    // leap month usually hits it so the leap path gets exercised.
    task automatic send_random();
        lsdc_pkg::t_in q;
        int yi;
        q = 23'($urandom);
        if ($urandom_range(9) < 8) begin
            q.in_year = 12'(1900 + $urandom_range(150));
            q.in_month = 4'($urandom_range(1, 12));
            q.in_day = 5'($urandom_range(1, 31));
            q.in_leap_month = ($urandom_range(3) == 0);
            if (q.cmd == lsdc_pkg::CMD_L2S) begin
                q.in_day = 5'($urandom_range(1, 30));
                yi = q.in_year - 1900;
                if (q.in_leap_month && sb.leap_no(yi) != 0 && $urandom_range(3) != 0)
                    q.in_month = 4'(sb.leap_no(yi));
            end
        end
        send_request(q);
    endtask

    task automatic drain();
        while (sb.pending_dates.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: table edges, first valid solar day, bad fields, leap cases.
        send_date(lsdc_pkg::CMD_S2L, 1900, 1, 30, 0);   // day zero, before first lunar day
        send_date(lsdc_pkg::CMD_S2L, 1900, 1, 31, 0);   // first lunar day
        send_date(lsdc_pkg::CMD_S2L, 2050, 12, 31, 0);  // last Gregorian day
        send_date(lsdc_pkg::CMD_S2L, 2050, 1, 23, 0);
        send_date(lsdc_pkg::CMD_S2L, 2000, 2, 29, 0);   // Gregorian leap day
        send_date(lsdc_pkg::CMD_S2L, 1900, 2, 29, 0);   // century non-leap
        send_date(lsdc_pkg::CMD_S2L, 1899, 12, 31, 0);
        send_date(lsdc_pkg::CMD_S2L, 2051, 1, 1, 0);
        send_date(lsdc_pkg::CMD_S2L, 2023, 0, 5, 0);
        send_date(lsdc_pkg::CMD_S2L, 2023, 13, 5, 0);
        send_date(lsdc_pkg::CMD_S2L, 2023, 4, 0, 0);
        send_date(lsdc_pkg::CMD_S2L, 2023, 4, 31, 0);
        send_date(lsdc_pkg::CMD_S2L, 2023, 4, 10, 0);   // inside a leap second month
        send_date(lsdc_pkg::CMD_L2S, 1900, 1, 1, 0);
        send_date(lsdc_pkg::CMD_L2S, 2050, 12, 30, 0);  // day 30 of a 29-day twelfth month
        send_date(lsdc_pkg::CMD_L2S, 2050, 3, 1, 1);    // leap third month of last year
        send_date(lsdc_pkg::CMD_L2S, 2023, 2, 30, 1);
        send_date(lsdc_pkg::CMD_L2S, 2023, 3, 1, 1);    // leap flag on wrong month
        send_date(lsdc_pkg::CMD_L2S, 2023, 1, 31, 0);
        send_date(lsdc_pkg::CMD_L2S, 2023, 15, 1, 0);
        send_date(lsdc_pkg::CMD_L2S, 4095, 15, 31, 1);
        send_date(lsdc_pkg::CMD_L2S, 0, 0, 0, 0);
        drain();
        // Hold off until the block is idle, then a clean request.
        send_date(lsdc_pkg::CMD_S2L, 1984, 2, 2, 0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (400) send_random();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (600) @(negedge i_clk);

        $display("Sent %0d requests; checked %0d conversions (%0d flagged invalid).",
                 n_sent, sb.n_checked, sb.n_invalid);
        $display("Covered edge dates, both directions, and four idle mixes.");
        if (sb.n_errors == 0 && sb.pending_dates.size() == 0)
            $display("tb_lunar_solar_date_convert passed");
        else
            $display("tb_lunar_solar_date_convert failed");
        $finish;
    end

    // Timeout for roughly 1600 requests, each a full conversion, plus stalls.
    initial begin
        #40000000;
        $display("tb_lunar_solar_date_convert failed");
        $finish;
    end

endmodule

// File: lunar_solar_date_convert.f
src/lsdc_pkg.sv
src/lsdc_rom.sv
src/lunar_solar_date_convert.sv
dv/tb_lunar_solar_date_convert.sv
